// File: rtl/core/thsbm_pkg.sv
package thsbm_pkg;

  // Sequencer steps, one-hot.
  typedef enum logic [20:0] {
    StIdle  = 21'h000001,
    StCrPre = 21'h000002,
    StCrHi  = 21'h000004,
    StCrLo  = 21'h000008,
    StTs0   = 21'h000010,
    StTs1   = 21'h000020,
    StTs2   = 21'h000040,
    StTs3   = 21'h000080,
    StTs4   = 21'h000100,
    StTs5   = 21'h000200,
    StTs6   = 21'h000400,
    StWrLo  = 21'h000800,
    StWrHi  = 21'h001000,
    StWaLo  = 21'h002000,
    StWaHi  = 21'h004000,
    StPoll  = 21'h008000,
    StRdLo  = 21'h010000,
    StRdHi  = 21'h020000,
    StRaLo  = 21'h040000,
    StRaHi  = 21'h080000,
    StDone  = 21'h100000
  } step_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgPhaseTicks    = 2'd0,
    CfgReadyPollLim  = 2'd1,
    CfgReadyPollTick = 2'd2
  } cfg_idx_e;

  localparam logic [7:0]  CmdHumidity    = 8'h05;
  localparam logic [7:0]  CmdTemperature = 8'h03;
  localparam logic [3:0]  ResetPulses    = 4'd9;
  localparam logic [3:0]  BitsPerByte    = 4'd8;
  localparam logic [1:0]  LastByte       = 2'd2;
  localparam logic [1:0]  FinalResetMark = 2'd3;

  localparam logic [7:0]  PhaseTicksRst  = 8'd1;
  localparam logic [7:0]  PollLimitRst   = 8'd6;
  localparam logic [15:0] PollTicksRst   = 16'd10;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned CfgDataW = 16;

  typedef struct packed {
    logic [7:0]  phase_ticks;
    logic [7:0]  ready_poll_limit;
    logic [15:0] ready_poll_ticks;
  } cfg_t;

  typedef struct packed {
    logic        scl;
    logic        sda_out;
    logic        sda_oe;
    logic        busy;
    logic        done;
    logic        ack_error;
    logic        timeout_error;
    logic [15:0] humidity_raw;
    logic [15:0] temperature_raw;
    logic [7:0]  humidity_check;
    logic [7:0]  temperature_check;
  } res_t;

endpackage

// File: rtl/core/thsbm_seq.sv
module thsbm_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  logic              start_i,
  input  logic              sda_i,
  input  thsbm_pkg::cfg_t   cfg_i,
  output thsbm_pkg::res_t   res_o
);

  thsbm_pkg::step_e step_q, step_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [1:0]  byte_cnt_q, byte_cnt_d;
  logic        meas_temp_q, meas_temp_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  tick_div_q, tick_div_d;
  logic [15:0] poll_timer_q, poll_timer_d;
  logic [7:0]  poll_cnt_q, poll_cnt_d;
  logic [15:0] hum_word_q, hum_word_d;
  logic [15:0] temp_word_q, temp_word_d;
  logic [7:0]  hum_sum_q, hum_sum_d;
  logic [7:0]  temp_sum_q, temp_sum_d;
  logic [1:0]  err_q, err_d;

  logic [7:0]  pt, pl;
  logic [15:0] pk;
  logic        phase_end;
  logic [3:0]  bit_inc;
  logic [1:0]  byte_inc;
  logic [7:0]  rd_shift;
  logic [15:0] timer_inc;
  logic [7:0]  cnt_inc;
  logic        poll_due;
  logic        go_rd;
  logic        scl, sdo, oe;

  // A zero in any timing register behaves as one.
  assign pt = (cfg_i.phase_ticks == 8'd0) ? 8'd1 : cfg_i.phase_ticks;
  assign pl = (cfg_i.ready_poll_limit == 8'd0) ? 8'd1 : cfg_i.ready_poll_limit;
  assign pk = (cfg_i.ready_poll_ticks == 16'd0) ? 16'd1 : cfg_i.ready_poll_ticks;

  assign phase_end = ({1'b0, tick_div_q} + 9'd1) >= {1'b0, pt};
  assign bit_inc   = bit_cnt_q + 4'd1;
  assign byte_inc  = byte_cnt_q + 2'd1;
  assign rd_shift  = {shift_q[6:0], sda_i};
  assign timer_inc = poll_timer_q + 16'd1;
  assign cnt_inc   = poll_cnt_q + 8'd1;
  assign poll_due  = (timer_inc >= pk) || (timer_inc == 16'd0);

  // Pin levels reflect the step at the start of the tick.
  always_comb begin
    scl = 1'b0;
    sdo = 1'b1;
    oe  = 1'b1;
    unique case (step_q)
      thsbm_pkg::StCrHi: scl = 1'b1;
      thsbm_pkg::StTs0: begin scl = 1'b1; sdo = 1'b1; end
      thsbm_pkg::StTs1: begin scl = 1'b1; sdo = 1'b0; end
      thsbm_pkg::StTs2: begin scl = 1'b0; sdo = 1'b0; end
      thsbm_pkg::StTs3: begin scl = 1'b1; sdo = 1'b0; end
      thsbm_pkg::StTs4: begin scl = 1'b1; sdo = 1'b1; end
      thsbm_pkg::StTs5: begin scl = 1'b0; sdo = 1'b1; end
      thsbm_pkg::StTs6: begin scl = 1'b0; sdo = 1'b0; end
      thsbm_pkg::StWrLo: sdo = shift_q[7];
      thsbm_pkg::StWrHi: begin scl = 1'b1; sdo = shift_q[7]; end
      thsbm_pkg::StWaLo, thsbm_pkg::StPoll, thsbm_pkg::StRdLo: oe = 1'b0;
      thsbm_pkg::StWaHi, thsbm_pkg::StRdHi: begin scl = 1'b1; oe = 1'b0; end
      thsbm_pkg::StRaLo: sdo = (byte_cnt_q == thsbm_pkg::LastByte);
      thsbm_pkg::StRaHi: begin scl = 1'b1; sdo = (byte_cnt_q == thsbm_pkg::LastByte); end
      default: ;
    endcase
  end

  assign res_o.scl               = scl;
  assign res_o.sda_out           = sdo;
  assign res_o.sda_oe            = oe;
  assign res_o.busy              = (step_q != thsbm_pkg::StIdle) &&
                                   (step_q != thsbm_pkg::StDone);
  assign res_o.done              = (step_q == thsbm_pkg::StDone);
  assign res_o.ack_error         = err_q[0];
  assign res_o.timeout_error     = err_q[1];
  assign res_o.humidity_raw      = hum_word_q;
  assign res_o.temperature_raw   = temp_word_q;
  assign res_o.humidity_check    = hum_sum_q;
  assign res_o.temperature_check = temp_sum_q;

  always_comb begin
    step_d       = step_q;
    bit_cnt_d    = bit_cnt_q;
    byte_cnt_d   = byte_cnt_q;
    meas_temp_d  = meas_temp_q;
    shift_d      = shift_q;
    tick_div_d   = tick_div_q;
    poll_timer_d = poll_timer_q;
    poll_cnt_d   = poll_cnt_q;
    hum_word_d   = hum_word_q;
    temp_word_d  = temp_word_q;
    hum_sum_d    = hum_sum_q;
    temp_sum_d   = temp_sum_q;
    err_d        = err_q;
    go_rd        = 1'b0;

    if (tick_i) begin
      unique case (step_q)
        thsbm_pkg::StIdle: begin
          if (start_i) begin
            err_d       = 2'b00;
            meas_temp_d = 1'b0;
            byte_cnt_d  = 2'd0;
            bit_cnt_d   = 4'd0;
            shift_d     = 8'd0;
            tick_div_d  = 8'd0;
            step_d      = thsbm_pkg::StCrPre;
          end
        end
        thsbm_pkg::StPoll: begin
          if (poll_due) begin
            poll_timer_d = 16'd0;
            if (!sda_i) begin
              go_rd = 1'b1;
            end else begin
              poll_cnt_d = cnt_inc;
              if ((cnt_inc >= pl) || (cnt_inc == 8'd0)) begin
                err_d[1] = 1'b1;
                go_rd    = 1'b1;
              end
            end
            if (go_rd) begin
              step_d     = thsbm_pkg::StRdLo;
              bit_cnt_d  = 4'd0;
              byte_cnt_d = 2'd0;
              shift_d    = 8'd0;
              tick_div_d = 8'd0;
            end
          end else begin
            poll_timer_d = timer_inc;
          end
        end
        thsbm_pkg::StCrPre, thsbm_pkg::StCrHi, thsbm_pkg::StCrLo,
        thsbm_pkg::StTs0, thsbm_pkg::StTs1, thsbm_pkg::StTs2, thsbm_pkg::StTs3,
        thsbm_pkg::StTs4, thsbm_pkg::StTs5, thsbm_pkg::StTs6,
        thsbm_pkg::StWrLo, thsbm_pkg::StWrHi, thsbm_pkg::StWaLo, thsbm_pkg::StWaHi,
        thsbm_pkg::StRdLo, thsbm_pkg::StRdHi, thsbm_pkg::StRaLo,
        thsbm_pkg::StRaHi: begin
          if (!phase_end) begin
            tick_div_d = tick_div_q + 8'd1;
          end else begin
            tick_div_d = 8'd0;
            unique case (step_q)
              thsbm_pkg::StCrPre: begin
                bit_cnt_d = 4'd0;
                step_d    = thsbm_pkg::StCrHi;
              end
              thsbm_pkg::StCrHi: step_d = thsbm_pkg::StCrLo;
              thsbm_pkg::StCrLo: begin
                if (bit_inc >= thsbm_pkg::ResetPulses) begin
                  bit_cnt_d = 4'd0;
                  step_d    = thsbm_pkg::StTs0;
                end else begin
                  bit_cnt_d = bit_inc;
                  step_d    = thsbm_pkg::StCrHi;
                end
              end
              thsbm_pkg::StTs0: step_d = thsbm_pkg::StTs1;
              thsbm_pkg::StTs1: step_d = thsbm_pkg::StTs2;
              thsbm_pkg::StTs2: step_d = thsbm_pkg::StTs3;
              thsbm_pkg::StTs3: step_d = thsbm_pkg::StTs4;
              thsbm_pkg::StTs4: step_d = thsbm_pkg::StTs5;
              thsbm_pkg::StTs5: step_d = thsbm_pkg::StTs6;
              thsbm_pkg::StTs6: begin
                // The final connection reset after an error ends here.
                if (byte_cnt_q == thsbm_pkg::FinalResetMark) begin
                  step_d = thsbm_pkg::StDone;
                end else begin
                  shift_d   = meas_temp_q ? thsbm_pkg::CmdTemperature
                                          : thsbm_pkg::CmdHumidity;
                  bit_cnt_d = 4'd0;
                  step_d    = thsbm_pkg::StWrLo;
                end
              end
              thsbm_pkg::StWrLo: step_d = thsbm_pkg::StWrHi;
              thsbm_pkg::StWrHi: begin
                shift_d = {shift_q[6:0], 1'b0};
                if (bit_inc >= thsbm_pkg::BitsPerByte) begin
                  bit_cnt_d = 4'd0;
                  step_d    = thsbm_pkg::StWaLo;
                end else begin
                  bit_cnt_d = bit_inc;
                  step_d    = thsbm_pkg::StWrLo;
                end
              end
              thsbm_pkg::StWaLo: step_d = thsbm_pkg::StWaHi;
              thsbm_pkg::StWaHi: begin
                if (sda_i) err_d[0] = 1'b1;
                poll_timer_d = 16'd0;
                poll_cnt_d   = 8'd0;
                step_d       = thsbm_pkg::StPoll;
              end
              thsbm_pkg::StRdLo: step_d = thsbm_pkg::StRdHi;
              thsbm_pkg::StRdHi: begin
                shift_d = rd_shift;
                if (bit_inc >= thsbm_pkg::BitsPerByte) begin
                  bit_cnt_d = 4'd0;
                  if (byte_cnt_q == 2'd0) begin
                    if (meas_temp_q) temp_word_d[15:8] = rd_shift;
                    else hum_word_d[15:8] = rd_shift;
                  end else if (byte_cnt_q == 2'd1) begin
                    if (meas_temp_q) temp_word_d[7:0] = rd_shift;
                    else hum_word_d[7:0] = rd_shift;
                  end else begin
                    if (meas_temp_q) temp_sum_d = rd_shift;
                    else hum_sum_d = rd_shift;
                  end
                  step_d = thsbm_pkg::StRaLo;
                end else begin
                  bit_cnt_d = bit_inc;
                  step_d    = thsbm_pkg::StRdLo;
                end
              end
              thsbm_pkg::StRaLo: step_d = thsbm_pkg::StRaHi;
              thsbm_pkg::StRaHi: begin
                shift_d    = 8'd0;
                byte_cnt_d = byte_inc;
                if (byte_inc == 2'd3) begin
                  if (!meas_temp_q) begin
                    meas_temp_d = 1'b1;
                    byte_cnt_d  = 2'd0;
                    step_d      = thsbm_pkg::StCrPre;
                  end else if (err_q != 2'b00) begin
                    byte_cnt_d = thsbm_pkg::FinalResetMark;
                    step_d     = thsbm_pkg::StCrPre;
                  end else begin
                    step_d = thsbm_pkg::StDone;
                  end
                end else begin
                  step_d = thsbm_pkg::StRdLo;
                end
              end
              default: step_d = thsbm_pkg::StIdle;
            endcase
          end
        end
        default: begin
          // Done tick and any stray code return to idle.
          step_d      = thsbm_pkg::StIdle;
          meas_temp_d = 1'b0;
          byte_cnt_d  = 2'd0;
          bit_cnt_d   = 4'd0;
          tick_div_d  = 8'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= thsbm_pkg::StIdle;
      bit_cnt_q    <= 4'd0;
      byte_cnt_q   <= 2'd0;
      meas_temp_q  <= 1'b0;
      shift_q      <= 8'd0;
      tick_div_q   <= 8'd0;
      poll_timer_q <= 16'd0;
      poll_cnt_q   <= 8'd0;
      hum_word_q   <= 16'd0;
      temp_word_q  <= 16'd0;
      hum_sum_q    <= 8'd0;
      temp_sum_q   <= 8'd0;
      err_q        <= 2'b00;
    end else begin
      step_q       <= step_d;
      bit_cnt_q    <= bit_cnt_d;
      byte_cnt_q   <= byte_cnt_d;
      meas_temp_q  <= meas_temp_d;
      shift_q      <= shift_d;
      tick_div_q   <= tick_div_d;
      poll_timer_q <= poll_timer_d;
      poll_cnt_q   <= poll_cnt_d;
      hum_word_q   <= hum_word_d;
      temp_word_q  <= temp_word_d;
      hum_sum_q    <= hum_sum_d;
      temp_sum_q   <= temp_sum_d;
      err_q        <= err_d;
    end
  end

  a_hold_without_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_i |=> $stable(step_q) && $stable(err_q) && $stable(tick_div_q))
    else $error("sequencer state moved without a tick");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_i && step_q == thsbm_pkg::StDone) |=> (step_q == thsbm_pkg::StIdle))
    else $error("done step did not return to idle");

  a_start_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_i && start_i && step_q == thsbm_pkg::StIdle) |=>
      (step_q == thsbm_pkg::StCrPre && err_q == 2'b00 && !meas_temp_q))
    else $error("start request did not begin a clean sequence");

  a_errors_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tick_i && step_q == thsbm_pkg::StIdle && start_i) |=>
      ((err_q & $past(err_q)) == $past(err_q)))
    else $error("error flag cleared without a new start");

endmodule

// File: rtl/core/temp_humidity_sensor_bus_master.sv
// Pin-level master for a two-wire temperature/humidity sensor. Every input
// request is one timing tick: tdata carries the start request (bit 0) and the
// sampled data line (bit 1). For each tick one result comes back with the
// clock and data pin levels, status flags and the latest raw humidity and
// temperature words and checksums, all as they stood at the start of that
// tick. A start while idle runs a connection reset, the start pattern,
// command 0x05 with acknowledge, ready polling and three byte reads, then the
// same for temperature with 0x03; an error adds a final connection reset.
// The block takes one tick per clock cycle: the sequencer state advances and
// the result register loads on the same edge.
// The input is ready whenever the result register is empty or its result is
// taken in the same cycle, so ticks flow back to back while the output side
// keeps up and the input stalls while a result waits downstream. The user
// writes the timing registers (phase ticks, ready poll limit, ready poll
// interval) via cfg only while no sequence runs; block does not enforce it.
module temp_humidity_sensor_bus_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] start_req, [1] sda_in, [7:2] zero
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl, [1] sda_out, [2] sda_oe, [3] busy_res, [4] done_res,
  // [5] ack_error, [6] timeout_error, [22:7] humidity_raw,
  // [38:23] temperature_raw, [46:39] humidity_check,
  // [54:47] temperature_check, [55] zero
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  thsbm_pkg::cfg_t cfg_q, cfg_d;
  thsbm_pkg::res_t res;
  logic            tick;
  logic            out_valid_q, out_valid_d;
  logic [55:0]     out_data_q, out_data_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        thsbm_pkg::CfgPhaseTicks:    cfg_d.phase_ticks      = cfg_wdata_i[7:0];
        thsbm_pkg::CfgReadyPollLim:  cfg_d.ready_poll_limit = cfg_wdata_i[7:0];
        thsbm_pkg::CfgReadyPollTick: cfg_d.ready_poll_ticks = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks      <= thsbm_pkg::PhaseTicksRst;
      cfg_q.ready_poll_limit <= thsbm_pkg::PollLimitRst;
      cfg_q.ready_poll_ticks <= thsbm_pkg::PollTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign tick          = s_axis_tvalid && s_axis_tready;

  thsbm_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (tick),
    .start_i (s_axis_tdata[0]),
    .sda_i   (s_axis_tdata[1]),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (tick) begin
      out_valid_d = 1'b1;
      out_data_d  = {1'b0, res.temperature_check, res.humidity_check,
                     res.temperature_raw, res.humidity_raw, res.timeout_error,
                     res.ack_error, res.done, res.busy, res.sda_oe,
                     res.sda_out, res.scl};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
